// ----- rtl/terminal_line_editor_assert.svh -----
// Assertion macros shared by the terminal line editor modules.
// Each macro expects signals named clock and reset in the including module.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// Checks a property at every clock edge outside reset.
`define TLE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define TLE_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tle_pkg.sv -----
// Package for the terminal line editor: payload structs, command codes,
// escape phases and character constants. No dependencies.
`default_nettype none

package tle_pkg;

   // Line buffer depth that bounds the store limit alongside max_len.
   localparam int unsigned LINE_DEPTH = 256;
   localparam logic [8:0]  LINE_DEPTH_CLAMP = 9'(LINE_DEPTH > 256 ? 256 : LINE_DEPTH);
   localparam logic [8:0]  MAX_LEN_RESET = 9'd256;

   // Command queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // Character codes.
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_OPEN_SQ = 8'h5B;
   localparam logic [7:0] CH_UPPER_O = 8'h4F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_DEL     = 8'h7F;

   // Escape sequence tracking.
   typedef enum logic [1:0] {
      ESC_IDLE  = 2'd0,
      ESC_AFTER = 2'd1,
      ESC_SEQ   = 2'd2
   } esc_phase_type;

   // Commands that the back part expands into results.
   typedef enum logic [1:0] {
      CMD_STORE   = 2'd0,
      CMD_ERASE   = 2'd1,
      CMD_NEWLINE = 2'd2,
      CMD_EOI     = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch_byte;
      logic [7:0]   pos;
      logic         empty;
   } cmd_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       more_waiting;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] out_byte;
      logic       store_valid;
      logic [7:0] store_index;
      logic       line_done;
      logic [7:0] line_length;
      logic       empty_at_end;
      logic       last;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/tle_front.sv -----
// Front part of the terminal line editor: accepts bytes, tracks escape
// sequences and the line position, and queues commands. Uses tle_pkg.
`default_nettype none

module tle_front import tle_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            csr_write_enable,
   input  wire logic [8:0]      csr_write_data,
   input  wire logic            queue_full,
   output logic                 cmd_push,
   output cmd_type              cmd_data
);

   esc_phase_type esc_phase_ff, esc_phase_in;
   logic [7:0]    line_pos_ff, line_pos_in;
   logic [8:0]    max_len_ff, max_len_in;
   logic [8:0]    len_clamp;
   logic [8:0]    store_limit;
   logic          accept;
   logic          is_letter;
   logic [7:0]    ch;

   // An item is taken whenever the queue has room and reset is low.
   assign req_ready = !queue_full && !reset;
   assign accept    = req_valid && req_ready;
   assign ch        = req_payload.in_byte;

   // Characters are stored only below min(max_len, depth) minus one.
   assign len_clamp   = (max_len_ff > LINE_DEPTH_CLAMP) ? LINE_DEPTH_CLAMP : max_len_ff;
   assign store_limit = (len_clamp == 9'd0) ? 9'd0 : len_clamp - 9'd1;

   assign is_letter = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
                      ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));

   // Configuration register.
   assign max_len_in = csr_write_enable ? csr_write_data : max_len_ff;

   // Classification of the accepted byte.
   always_comb begin
      esc_phase_in     = esc_phase_ff;
      line_pos_in      = line_pos_ff;
      cmd_push         = 1'b0;
      cmd_data.kind    = CMD_STORE;
      cmd_data.ch_byte = ch;
      cmd_data.pos     = line_pos_ff;
      cmd_data.empty   = 1'b0;
      if (accept) begin
         if (req_payload.end_of_input) begin
            cmd_push       = 1'b1;
            cmd_data.kind  = CMD_EOI;
            cmd_data.empty = (line_pos_ff == 8'd0);
            esc_phase_in   = ESC_IDLE;
            line_pos_in    = 8'd0;
         end else begin
            unique case (esc_phase_ff)
               ESC_AFTER: begin
                  esc_phase_in = ((ch == CH_OPEN_SQ) || (ch == CH_UPPER_O)) ? ESC_SEQ
                                                                           : ESC_IDLE;
               end
               ESC_SEQ: begin
                  if (is_letter || (ch == CH_TILDE)) begin
                     esc_phase_in = ESC_IDLE;
                  end
               end
               default: begin
                  // Idle, and the unused phase code behaves as idle.
                  esc_phase_in = ESC_IDLE;
                  if (ch == CH_ESC) begin
                     if (req_payload.more_waiting) begin
                        esc_phase_in = ESC_AFTER;
                     end
                  end else if ((ch == CH_BS) || (ch == CH_DEL)) begin
                     if (line_pos_ff != 8'd0) begin
                        cmd_push      = 1'b1;
                        cmd_data.kind = CMD_ERASE;
                        line_pos_in   = line_pos_ff - 8'd1;
                     end
                  end else if ((ch == CH_CR) || (ch == CH_LF)) begin
                     cmd_push      = 1'b1;
                     cmd_data.kind = CMD_NEWLINE;
                     line_pos_in   = 8'd0;
                  end else if ((ch >= CH_SPACE) && (ch < CH_DEL)) begin
                     if ({1'b0, line_pos_ff} < store_limit) begin
                        cmd_push      = 1'b1;
                        cmd_data.kind = CMD_STORE;
                        line_pos_in   = line_pos_ff + 8'd1;
                     end
                  end
               end
            endcase
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_phase_ff <= ESC_IDLE;
         line_pos_ff  <= 8'd0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         esc_phase_ff <= esc_phase_in;
         line_pos_ff  <= line_pos_in;
         max_len_ff   <= max_len_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tle_queue.sv -----
// Short command queue between the front and back parts of the line editor.
// Uses tle_pkg and the assertion macros header.
`default_nettype none

`include "terminal_line_editor_assert.svh"

module tle_queue import tle_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_data
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TLE_ASSERT(a_count_bound, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `TLE_ASSERT(a_no_pop_empty, !pop || head_valid, "pop from an empty queue")
   `TLE_ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + 1'b1, "lost push")

endmodule

`default_nettype wire

// ----- rtl/tle_back.sv -----
// Back part of the line editor: expands queued commands into results and
// holds them in the output register. Uses tle_pkg and the assertion macros.
`default_nettype none

`include "terminal_line_editor_assert.svh"

module tle_back import tle_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [1:0]      step_ff, step_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   rsp_payload_type result;
   logic            final_step;
   logic            load;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The output register takes a new result when empty or being drained.
   assign load = !rsp_valid_ff || rsp_ready;

   // Result for the current step of the head command.
   always_comb begin
      result     = '0;
      final_step = 1'b1;
      unique case (cmd_data.kind)
         CMD_STORE: begin
            result.echo_valid  = 1'b1;
            result.out_byte    = cmd_data.ch_byte;
            result.store_valid = 1'b1;
            result.store_index = cmd_data.pos;
         end
         CMD_ERASE: begin
            result.echo_valid = 1'b1;
            result.out_byte   = (step_ff == 2'd1) ? CH_SPACE : CH_BS;
            final_step        = (step_ff == 2'd2);
         end
         CMD_NEWLINE: begin
            result.echo_valid = 1'b1;
            if (step_ff == 2'd0) begin
               result.out_byte = CH_CR;
               final_step      = 1'b0;
            end else begin
               result.out_byte    = CH_LF;
               result.line_done   = 1'b1;
               result.line_length = cmd_data.pos;
            end
         end
         CMD_EOI: begin
            result.line_done    = 1'b1;
            result.line_length  = cmd_data.pos;
            result.empty_at_end = cmd_data.empty;
         end
         default: begin
            result = '0;
         end
      endcase
      result.last = final_step;
   end

   // Sequencing over the steps of one command.
   always_comb begin
      cmd_pop      = 1'b0;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = cmd_valid;
         rsp_data_in  = result;
         if (cmd_valid) begin
            if (final_step) begin
               cmd_pop = 1'b1;
               step_in = 2'd0;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `TLE_ASSERT(a_step_has_cmd, (step_ff == 2'd0) || cmd_valid, "command left mid-sequence")
   `TLE_ASSERT(a_single_step, !cmd_valid || !((cmd_data.kind == CMD_STORE) || (cmd_data.kind == CMD_EOI)) || (step_ff == 2'd0), "single-result command past first step")
   `TLE_ASSERT(a_newline_steps, !cmd_valid || (cmd_data.kind != CMD_NEWLINE) || (step_ff <= 2'd1), "newline past second step")

endmodule

`default_nettype wire

// ----- rtl/terminal_line_editor.sv -----
// Throughput: one byte is accepted per cycle while the command queue has room; the
// back part emits one result per cycle while rsp_ready holds; an erase yields three
// results, a newline two. Results pass a queue entry, then the output register.
// Reset (synchronous): escape phase idle, position 0, queue empty, max_len 256.
// Depends on tle_pkg, tle_front, tle_queue and tle_back.
`default_nettype none

module terminal_line_editor import tle_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_write_enable,
   input  wire logic [8:0]      csr_write_data
);

   logic    queue_full;
   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_pop;
   logic    head_valid;
   cmd_type head_data;

   // Classification of incoming bytes.
   tle_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_in)
   );

   // Decoupling queue.
   tle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_in),
      .pop        (cmd_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Result generation.
   tle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd_data    (head_data),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
